>>> sv/bpdc_pkg.sv
// shared types and constants for the bmp pixel depth converter
// no dependencies; imported by every module of the block
`default_nettype none

package bpdc_pkg;

    localparam int CFG_W    = 13;
    localparam int QDEPTH   = 4;
    localparam int QAW      = 2;

    // configuration register indexes
    localparam logic [1:0] REG_CONV_MODE    = 2'd0;
    localparam logic [1:0] REG_WIDTH_PIXELS = 2'd1;
    localparam logic [1:0] REG_HEIGHT_ROWS  = 2'd2;

    // conversion modes
    localparam logic MODE_24_TO_16 = 1'b0;
    localparam logic MODE_16_TO_24 = 1'b1;

    typedef struct packed {
        logic             mode;
        logic [CFG_W-1:0] width_pixels;
        logic [CFG_W-1:0] height_rows;
    } t_cfg;

    // one converted pixel waiting for the output side
    typedef struct packed {
        logic        mode;
        logic [15:0] px;       // packed rgb555 word (mode 0) or raw source word (mode 1)
        logic [1:0]  opad;     // zero bytes appended after the pixel
        logic        row_end;
        logic        img_end;
    } t_job;

    // 5-bit channel to 8-bit, c*255/31 rounded down
    localparam logic [7:0] EXPAND5 [32] = '{
        8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
        8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
        8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
        8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
    };

    // zero reads as one, anything above the limit saturates
    function automatic logic [31:0] clamp_size(logic [CFG_W-1:0] v, logic [31:0] maxv);
        logic [31:0] v32;
        v32 = {{(32-CFG_W){1'b0}}, v};
        if (v32 == 32'd0) begin
            return 32'd1;
        end else if (v32 > maxv) begin
            return maxv;
        end
        return v32;
    endfunction

endpackage

`default_nettype wire

>>> sv/bmp_pixel_depth_converter.sv
// bmp pixel depth converter, top level: configuration registers and the
// front end, pixel queue and back end; uses bpdc_pkg
//
// Source pixel bytes of a bottom-up BMP image enter on the input channel,
// row padding included, one byte per transaction. Mode 0 turns each B,G,R
// triple into a little-endian rgb555 word (two bytes); mode 1 turns each
// rgb555 word into B,G,R bytes. Output rows are zero padded to a multiple
// of four bytes after the row's last pixel; input padding is dropped.
// Config writes (index 0 mode, 1 width, 2 height) are always accepted and
// return the stream to the start of an image; write them only when idle.
// Input takes one byte per cycle while the queue has room; the output side
// delivers one byte per cycle while a pixel is queued and the receiver is
// ready; mode 0 emits 2/3 byte per input byte, mode 1 3/2, plus row padding,
// so the back end sets the sustained rate in mode 1. A pixel's first output
// byte passes the queue write, then the output register load. The four-entry
// queue absorbs stalls of the receiver; when it fills, input ready drops
// on the byte that would complete a pixel. Reset restores mode 0, width 1,
// height 1 and empties the queue and output register.
`default_nettype none

module bmp_pixel_depth_converter import bpdc_pkg::*; #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [1:0]       i_cfg_index,
    input  wire logic [CFG_W-1:0] i_cfg_data,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire logic [7:0]       i_in_byte,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic [7:0]            o_out_byte,
    output logic                  o_last_of_run,
    output logic                  o_row_done,
    output logic                  o_image_done
);

    t_cfg r_cfg;
    logic cfg_write, clear;
    logic q_push, q_full, q_pop, q_not_empty;
    t_job push_job, head_job;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;
    // an unknown index leaves the configuration registers and stream position alone
    assign clear = cfg_write && (i_cfg_index == REG_CONV_MODE ||
                                 i_cfg_index == REG_WIDTH_PIXELS ||
                                 i_cfg_index == REG_HEIGHT_ROWS);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode         <= MODE_24_TO_16;
            r_cfg.width_pixels <= CFG_W'(1);
            r_cfg.height_rows  <= CFG_W'(1);
        end else if (cfg_write) begin
            case (i_cfg_index)
                REG_CONV_MODE:    r_cfg.mode         <= i_cfg_data[0];
                REG_WIDTH_PIXELS: r_cfg.width_pixels <= i_cfg_data;
                REG_HEIGHT_ROWS:  r_cfg.height_rows  <= i_cfg_data;
                default:          r_cfg              <= r_cfg;
            endcase
        end
    end

    bpdc_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_clear    (clear),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_byte  (i_in_byte),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_job      (push_job)
    );

    bpdc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_job       (push_job),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_not_empty (q_not_empty),
        .o_job       (head_job)
    );

    bpdc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_not_empty (q_not_empty),
        .i_job         (head_job),
        .o_pop         (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_byte    (o_out_byte),
        .o_last_of_run (o_last_of_run),
        .o_row_done    (o_row_done),
        .o_image_done  (o_image_done)
    );

endmodule

`default_nettype wire

>>> sv/bpdc_front.sv
// front end: accepts source bytes, drops row padding, gathers pixels,
// tracks column and row position; uses bpdc_pkg
`default_nettype none

module bpdc_front import bpdc_pkg::*; #(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cfg       i_cfg,
    input  wire logic       i_clear,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_in_byte,
    input  wire logic       i_q_full,
    output logic            o_push,
    output t_job            o_job
);

    localparam int CW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic [1:0]    r_phase, n_phase;
    logic [15:0]   r_held, n_held;
    logic [CW-1:0] r_col, n_col;
    logic [RW-1:0] r_row, n_row;
    logic [1:0]    r_pad, n_pad;

    logic [31:0] w32, h32;
    logic        complete, accept, row_end, img_end;
    logic [1:0]  pad2, pad3, opad, ipad;

    assign w32 = clamp_size(i_cfg.width_pixels, 32'(MAX_WIDTH));
    assign h32 = clamp_size(i_cfg.height_rows, 32'(MAX_HEIGHT));

    // 2w mod 4 for 16-bit rows, (-3w) mod 4 = w mod 4 for 24-bit rows
    assign pad2 = {w32[0], 1'b0};
    assign pad3 = w32[1:0];

    assign complete = (r_pad == 2'd0) &&
                      ((i_cfg.mode == MODE_16_TO_24) ? (r_phase != 2'd0) : (r_phase == 2'd2));
    assign o_in_ready = !complete || !i_q_full;
    assign accept     = i_in_valid && o_in_ready;

    assign row_end = (32'(r_col) + 32'd1) >= w32;
    assign img_end = row_end && ((32'(r_row) + 32'd1) >= h32);
    assign opad    = (i_cfg.mode == MODE_16_TO_24) ? pad3 : pad2;
    assign ipad    = (i_cfg.mode == MODE_16_TO_24) ? pad2 : pad3;

    always_comb begin
        o_job.mode    = i_cfg.mode;
        o_job.row_end = row_end;
        o_job.img_end = img_end;
        o_job.opad    = row_end ? opad : 2'd0;
        if (i_cfg.mode == MODE_16_TO_24) begin
            o_job.px = {i_in_byte, r_held[7:0]};
        end else begin
            o_job.px = {1'b0, i_in_byte[7:3], r_held[15:11], r_held[7:3]};
        end
    end

    assign o_push = accept && complete;

    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        n_col   = r_col;
        n_row   = r_row;
        n_pad   = r_pad;
        if (i_clear) begin
            n_phase = 2'd0;
            n_held  = 16'd0;
            n_col   = '0;
            n_row   = '0;
            n_pad   = 2'd0;
        end else if (accept) begin
            if (r_pad != 2'd0) begin
                n_pad = r_pad - 2'd1;
            end else if (complete) begin
                n_phase = 2'd0;
                n_held  = 16'd0;
                if (row_end) begin
                    n_col = '0;
                    n_pad = ipad;
                    n_row = img_end ? '0 : RW'(32'(r_row) + 32'd1);
                end else begin
                    n_col = CW'(32'(r_col) + 32'd1);
                end
            end else if (r_phase == 2'd0) begin
                n_held  = {8'd0, i_in_byte};
                n_phase = 2'd1;
            end else begin
                n_held  = {i_in_byte, r_held[7:0]};
                n_phase = 2'd2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 2'd0;
            r_col   <= '0;
            r_row   <= '0;
            r_pad   <= 2'd0;
        end else begin
            r_phase <= n_phase;
            r_col   <= n_col;
            r_row   <= n_row;
            r_pad   <= n_pad;
        end
    end

    always_ff @(posedge i_clk) begin
        r_held <= n_held;
    end

    // padding is only skipped between whole pixels
    a_pad_between_pixels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pad != 2'd0) |-> (r_phase == 2'd0))
        else $error("front: padding skip inside a pixel");

endmodule

`default_nettype wire

>>> sv/bpdc_queue.sv
// short pixel queue between front and back ends
// uses bpdc_pkg for the entry type and depth
`default_nettype none

module bpdc_queue import bpdc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_not_empty,
    output t_job      o_job
);

    t_job           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr, r_rd;
    logic [QAW:0]   r_count;

    assign o_full      = (r_count == (QAW+1)'(QDEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_job       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QAW+1)'(QDEPTH))
        else $error("queue: occupancy above depth");

    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue: push lost");

endmodule

`default_nettype wire

>>> sv/bpdc_back.sv
// back end: expands one queued pixel into its output bytes and row padding,
// holds them in an output register; uses bpdc_pkg
`default_nettype none

module bpdc_back import bpdc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_q_not_empty,
    input  wire t_job i_job,
    output logic      o_pop,
    output logic       o_out_valid,
    input  wire logic  i_out_ready,
    output logic [7:0] o_out_byte,
    output logic       o_last_of_run,
    output logic       o_row_done,
    output logic       o_image_done
);

    logic [2:0] r_idx;
    logic       r_ov;
    logic [7:0] r_byte;
    logic       r_last, r_row, r_img;

    logic [2:0] n_total;
    logic       load, last;
    logic [7:0] sel_byte;

    assign n_total = ((i_job.mode == MODE_16_TO_24) ? 3'd3 : 3'd2) + {1'b0, i_job.opad};
    assign last    = (r_idx == n_total - 3'd1);
    assign load    = i_q_not_empty && (!r_ov || i_out_ready);
    assign o_pop   = load && last;

    always_comb begin
        sel_byte = 8'd0;
        if (i_job.mode == MODE_16_TO_24) begin
            case (r_idx)
                3'd0:    sel_byte = EXPAND5[i_job.px[4:0]];
                3'd1:    sel_byte = EXPAND5[i_job.px[9:5]];
                3'd2:    sel_byte = EXPAND5[i_job.px[14:10]];
                default: sel_byte = 8'd0;
            endcase
        end else begin
            case (r_idx)
                3'd0:    sel_byte = i_job.px[7:0];
                3'd1:    sel_byte = i_job.px[15:8];
                default: sel_byte = 8'd0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 3'd0;
            r_ov  <= 1'b0;
        end else if (load) begin
            r_idx <= last ? 3'd0 : r_idx + 3'd1;
            r_ov  <= 1'b1;
        end else if (i_out_ready) begin
            r_ov  <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= sel_byte;
            r_last <= last;
            r_row  <= last && i_job.row_end;
            r_img  <= last && i_job.img_end;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_out_byte    = r_byte;
    assign o_last_of_run = r_last;
    assign o_row_done    = r_row;
    assign o_image_done  = r_img;

    a_image_end_closes_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_img) |-> (r_row && r_last))
        else $error("back: image end without row end");

endmodule

`default_nettype wire
